// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the address mode bus unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/amb_pkg.sv -----
// Shared types, codes and constants of the address mode bus unit.
package amb_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int RAM_AW    = $clog2(MEM_DEPTH);
  localparam bit MEM_POW2  = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  localparam int MOD_STEPS = $clog2(65535 / MEM_DEPTH + 1);
  localparam logic [RAM_AW-1:0] LAST_IDX = RAM_AW'(MEM_DEPTH - 1);

  localparam logic [15:0] PAGE_MASK = 16'hFF00;
  localparam logic [15:0] LOW_MASK  = 16'h00FF;

  localparam logic [2:0] OP_WR_BYTE = 3'd0;
  localparam logic [2:0] OP_RD_BYTE = 3'd1;
  localparam logic [2:0] OP_ADDR    = 3'd2;
  localparam logic [2:0] OP_RD_MODE = 3'd3;
  localparam logic [2:0] OP_WR_MODE = 3'd4;

  localparam logic [3:0] MODE_ABS  = 4'd0;
  localparam logic [3:0] MODE_IMM  = 4'd1;
  localparam logic [3:0] MODE_ABSX = 4'd2;
  localparam logic [3:0] MODE_ZPX  = 4'd3;
  localparam logic [3:0] MODE_IZX  = 4'd4;
  localparam logic [3:0] MODE_ABSY = 4'd5;
  localparam logic [3:0] MODE_ZPY  = 4'd6;
  localparam logic [3:0] MODE_ZP   = 4'd7;
  localparam logic [3:0] MODE_IZY  = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OPLO,
    ST_OPHI,
    ST_DUMMY,
    ST_PTRLO,
    ST_PTRHI,
    ST_CROSS,
    ST_FINAL,
    ST_WAIT,
    ST_NOBUS
  } amb_state_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] idx;
    logic [7:0]        wdata;
  } amb_mem_req_t;

  typedef struct packed {
    logic        bus_valid;
    logic [15:0] bus_addr;
    logic [7:0]  bus_value;
    logic        bus_write;
    logic        last;
    logic [15:0] effective_addr;
    logic [15:0] pc_out;
    logic        idx_carry;
    logic        mode_error;
    logic [7:0]  read_data;
  } amb_res_t;

  function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] a);
    logic [16:0] r;
    logic [16:0] step;
    r    = {1'b0, a};
    step = '0;
    if (!MEM_POW2) begin
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
        step = 17'(MEM_DEPTH) << k;
        if (r >= step) begin
          r = r - step;
        end
      end
    end
    return r[RAM_AW-1:0];
  endfunction

endpackage

// ----- hw/rtl/amb_if.sv -----
// Request and result channel interfaces of the address mode bus unit.
interface amb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  mode;
  logic [15:0] address;
  logic [7:0]  data_in;
  logic [15:0] pc_in;
  logic [7:0]  x_index;
  logic [7:0]  y_index;

  modport source (
    output valid, op, mode, address, data_in, pc_in, x_index, y_index,
    input  ready
  );
  modport sink (
    input  valid, op, mode, address, data_in, pc_in, x_index, y_index,
    output ready
  );
endinterface

interface amb_out_if;
  logic        valid;
  logic        ready;
  logic        bus_valid;
  logic [15:0] bus_addr;
  logic [7:0]  bus_value;
  logic        bus_write;
  logic        last;
  logic [15:0] effective_addr;
  logic [15:0] pc_out;
  logic        idx_carry;
  logic        mode_error;
  logic [7:0]  read_data;

  modport source (
    output valid, bus_valid, bus_addr, bus_value, bus_write, last,
           effective_addr, pc_out, idx_carry, mode_error, read_data,
    input  ready
  );
  modport sink (
    input  valid, bus_valid, bus_addr, bus_value, bus_write, last,
           effective_addr, pc_out, idx_carry, mode_error, read_data,
    output ready
  );
endinterface

// ----- hw/rtl/amb_ram.sv -----
// Single-port synchronous RAM with registered read data.
module amb_ram #(
  parameter int DEPTH = 512,
  parameter int DW    = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/amb_seq.sv -----
// Bus cycle sequencer: addressing mode steps, RAM clearing and result register.
`include "assert_macros.svh"

module amb_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  amb_in_if.sink                in_req,
  amb_out_if.source             out_res,
  output amb_pkg::amb_mem_req_t mem_req,
  input  logic [7:0]            mem_rdata
);

  amb_pkg::amb_state_t state_r, state_nxt;
  amb_pkg::amb_state_t kind_r, kind_nxt;
  logic [amb_pkg::RAM_AW-1:0] clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  amb_pkg::amb_res_t          out_r, out_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  zp_r, zp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] ea_r, ea_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        cross_r, cross_nxt;
  logic        err_r, err_nxt;

  logic        slot_ok;
  logic        accept;
  logic        issue_st;
  logic        issuing;
  logic        is_write;
  logic        is_read;
  logic [15:0] acc_addr;

  amb_pkg::amb_state_t in_st;
  logic [15:0]         in_ea;
  logic [15:0]         in_pc;
  logic                in_err;

  amb_pkg::amb_state_t dec_st;
  logic [15:0]         dec_ea;
  logic [15:0]         dec_base;
  logic                dec_cross;
  logic                dec_done;
  logic                dec_last;
  logic [7:0]          dec_ix;
  logic [15:0]         dec_ptr;
  logic [15:0]         dec_sum;

  amb_pkg::amb_res_t   res_wait;
  amb_pkg::amb_res_t   res_nobus;

  assign slot_ok  = !out_valid_r || out_res.ready;
  assign accept   = in_req.valid && in_req.ready;
  assign is_write = (op_r == amb_pkg::OP_WR_BYTE) || (op_r == amb_pkg::OP_WR_MODE);
  assign is_read  = (op_r == amb_pkg::OP_RD_BYTE) || (op_r == amb_pkg::OP_RD_MODE);
  assign issue_st = (state_r == amb_pkg::ST_OPLO)  || (state_r == amb_pkg::ST_OPHI)  ||
                    (state_r == amb_pkg::ST_DUMMY) || (state_r == amb_pkg::ST_PTRLO) ||
                    (state_r == amb_pkg::ST_PTRHI) || (state_r == amb_pkg::ST_CROSS) ||
                    (state_r == amb_pkg::ST_FINAL);
  assign issuing  = issue_st && slot_ok;

  // decode a new request
  always_comb begin
    in_st  = amb_pkg::ST_NOBUS;
    in_ea  = '0;
    in_pc  = in_req.pc_in;
    in_err = 1'b0;
    case (in_req.op)
      amb_pkg::OP_WR_BYTE, amb_pkg::OP_RD_BYTE: begin
        in_ea = in_req.address;
        in_st = amb_pkg::ST_FINAL;
      end
      amb_pkg::OP_ADDR, amb_pkg::OP_RD_MODE, amb_pkg::OP_WR_MODE: begin
        if (in_req.mode > amb_pkg::MODE_IZY) begin
          in_err = 1'b1;
        end else if (in_req.mode == amb_pkg::MODE_IMM) begin
          in_ea = in_req.pc_in;
          in_pc = in_req.pc_in + 16'd1;
          in_st = (in_req.op == amb_pkg::OP_ADDR) ? amb_pkg::ST_NOBUS : amb_pkg::ST_FINAL;
        end else begin
          in_st = amb_pkg::ST_OPLO;
        end
      end
      default: begin
        in_st = amb_pkg::ST_NOBUS;
      end
    endcase
  end

  // address of the bus cycle issued from the current state
  always_comb begin
    case (state_r)
      amb_pkg::ST_OPLO, amb_pkg::ST_OPHI: acc_addr = pc_r;
      amb_pkg::ST_DUMMY, amb_pkg::ST_PTRLO: acc_addr = {8'h00, zp_r};
      amb_pkg::ST_PTRHI: acc_addr = {8'h00, zp_r + 8'd1};
      amb_pkg::ST_CROSS: acc_addr = (base_r & amb_pkg::PAGE_MASK) | (ea_r & amb_pkg::LOW_MASK);
      default:           acc_addr = ea_r;
    endcase
  end

  // decode returned RAM data
  always_comb begin
    dec_st    = amb_pkg::ST_IDLE;
    dec_ea    = ea_r;
    dec_base  = base_r;
    dec_cross = cross_r;
    dec_done  = 1'b0;
    dec_ix    = ((mode_r == amb_pkg::MODE_ABSX) || (mode_r == amb_pkg::MODE_ZPX)) ? x_r : y_r;
    dec_ptr   = {mem_rdata, lo_r};
    dec_sum   = dec_ptr + {8'h00, dec_ix};
    case (kind_r)
      amb_pkg::ST_OPLO: begin
        case (mode_r)
          amb_pkg::MODE_ABS, amb_pkg::MODE_ABSX, amb_pkg::MODE_ABSY: begin
            dec_st = amb_pkg::ST_OPHI;
          end
          amb_pkg::MODE_ZPX, amb_pkg::MODE_ZPY, amb_pkg::MODE_IZX: begin
            dec_st = amb_pkg::ST_DUMMY;
          end
          amb_pkg::MODE_IZY: begin
            dec_st = amb_pkg::ST_PTRLO;
          end
          amb_pkg::MODE_ZP: begin
            dec_ea   = {8'h00, mem_rdata};
            dec_done = 1'b1;
          end
          default: begin
            dec_done = 1'b1;
          end
        endcase
      end
      amb_pkg::ST_OPHI, amb_pkg::ST_PTRHI: begin
        if ((mode_r == amb_pkg::MODE_ABS) || (mode_r == amb_pkg::MODE_IZX)) begin
          dec_ea   = dec_ptr;
          dec_done = 1'b1;
        end else begin
          dec_ea   = dec_sum;
          dec_base = dec_ptr;
          if ((dec_sum & amb_pkg::PAGE_MASK) != (dec_ptr & amb_pkg::PAGE_MASK)) begin
            dec_cross = 1'b1;
            dec_st    = amb_pkg::ST_CROSS;
          end else begin
            dec_done = 1'b1;
          end
        end
      end
      amb_pkg::ST_DUMMY: begin
        if (mode_r == amb_pkg::MODE_IZX) begin
          dec_st = amb_pkg::ST_PTRLO;
        end else begin
          dec_ea   = {8'h00, zp_r + dec_ix};
          dec_done = 1'b1;
        end
      end
      amb_pkg::ST_PTRLO: begin
        dec_st = amb_pkg::ST_PTRHI;
      end
      amb_pkg::ST_CROSS: begin
        dec_done = 1'b1;
      end
      default: begin
        dec_st = amb_pkg::ST_IDLE;
      end
    endcase
    if (dec_done) begin
      dec_st = (op_r == amb_pkg::OP_ADDR) ? amb_pkg::ST_IDLE : amb_pkg::ST_FINAL;
    end
    dec_last = (dec_st == amb_pkg::ST_IDLE);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amb_pkg::ST_CLEAR: begin
        if (clr_r == amb_pkg::LAST_IDX) begin
          state_nxt = amb_pkg::ST_IDLE;
        end
      end
      amb_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = in_st;
        end
      end
      amb_pkg::ST_OPLO, amb_pkg::ST_OPHI, amb_pkg::ST_DUMMY, amb_pkg::ST_PTRLO,
      amb_pkg::ST_PTRHI, amb_pkg::ST_CROSS, amb_pkg::ST_FINAL: begin
        if (slot_ok) begin
          state_nxt = amb_pkg::ST_WAIT;
        end
      end
      amb_pkg::ST_WAIT: begin
        state_nxt = dec_st;
      end
      amb_pkg::ST_NOBUS: begin
        if (slot_ok) begin
          state_nxt = amb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = amb_pkg::ST_IDLE;
      end
    endcase
  end

  // result words
  always_comb begin
    res_wait           = '0;
    res_wait.bus_valid = 1'b1;
    res_wait.bus_addr  = acc_r;
    res_wait.bus_write = (kind_r == amb_pkg::ST_FINAL) && is_write;
    res_wait.bus_value = res_wait.bus_write ? data_r : mem_rdata;
    res_wait.last      = dec_last;
    if (dec_last) begin
      res_wait.effective_addr = dec_ea;
      res_wait.pc_out         = pc_r;
      res_wait.idx_carry      = dec_cross;
      res_wait.read_data      = ((kind_r == amb_pkg::ST_FINAL) && is_read) ? mem_rdata : 8'h00;
    end
    res_nobus                = '0;
    res_nobus.last           = 1'b1;
    res_nobus.effective_addr = ea_r;
    res_nobus.pc_out         = pc_r;
    res_nobus.mode_error     = err_r;
  end

  // datapath next values
  always_comb begin
    op_nxt        = op_r;
    mode_nxt      = mode_r;
    data_nxt      = data_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    lo_nxt        = lo_r;
    zp_nxt        = zp_r;
    pc_nxt        = pc_r;
    ea_nxt        = ea_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    cross_nxt     = cross_r;
    err_nxt       = err_r;
    kind_nxt      = kind_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    if (state_r == amb_pkg::ST_CLEAR) begin
      clr_nxt = clr_r + {{(amb_pkg::RAM_AW-1){1'b0}}, 1'b1};
    end
    if (accept) begin
      op_nxt    = in_req.op;
      mode_nxt  = in_req.mode;
      data_nxt  = in_req.data_in;
      x_nxt     = in_req.x_index;
      y_nxt     = in_req.y_index;
      pc_nxt    = in_pc;
      ea_nxt    = in_ea;
      err_nxt   = in_err;
      cross_nxt = 1'b0;
    end
    if (issuing) begin
      acc_nxt  = acc_addr;
      kind_nxt = state_r;
      if ((state_r == amb_pkg::ST_OPLO) || (state_r == amb_pkg::ST_OPHI)) begin
        pc_nxt = pc_r + 16'd1;
      end
    end
    if (state_r == amb_pkg::ST_WAIT) begin
      if ((kind_r == amb_pkg::ST_OPLO) || (kind_r == amb_pkg::ST_PTRLO)) begin
        lo_nxt = mem_rdata;
      end
      if (kind_r == amb_pkg::ST_OPLO) begin
        zp_nxt = mem_rdata;
      end else if ((kind_r == amb_pkg::ST_DUMMY) && (mode_r == amb_pkg::MODE_IZX)) begin
        zp_nxt = zp_r + x_r;
      end
      ea_nxt        = dec_ea;
      base_nxt      = dec_base;
      cross_nxt     = dec_cross;
      out_nxt       = res_wait;
      out_valid_nxt = 1'b1;
    end
    if ((state_r == amb_pkg::ST_NOBUS) && slot_ok) begin
      out_nxt       = res_nobus;
      out_valid_nxt = 1'b1;
    end
  end

  // outputs
  always_comb begin
    in_req.ready  = (state_r == amb_pkg::ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.idx   = amb_pkg::ram_index(acc_addr);
    mem_req.wdata = data_r;
    if (state_r == amb_pkg::ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.idx   = clr_r;
      mem_req.wdata = 8'h00;
    end else if (issuing && (state_r == amb_pkg::ST_FINAL) && is_write) begin
      mem_req.we = 1'b1;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.bus_valid      = out_r.bus_valid;
  assign out_res.bus_addr       = out_r.bus_addr;
  assign out_res.bus_value      = out_r.bus_value;
  assign out_res.bus_write      = out_r.bus_write;
  assign out_res.last           = out_r.last;
  assign out_res.effective_addr = out_r.effective_addr;
  assign out_res.pc_out         = out_r.pc_out;
  assign out_res.idx_carry      = out_r.idx_carry;
  assign out_res.mode_error     = out_r.mode_error;
  assign out_res.read_data      = out_r.read_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amb_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    mode_r  <= mode_nxt;
    data_r  <= data_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    lo_r    <= lo_nxt;
    zp_r    <= zp_nxt;
    pc_r    <= pc_nxt;
    ea_r    <= ea_nxt;
    base_r  <= base_nxt;
    acc_r   <= acc_nxt;
    cross_r <= cross_nxt;
    err_r   <= err_nxt;
    kind_r  <= kind_nxt;
    out_r   <= out_nxt;
  end

  `ASSERT_SYNC(a_wait_slot_free, clk, rst_n, (state_r == amb_pkg::ST_WAIT) |-> !out_valid_r, "result slot busy when RAM data returns")
  `ASSERT_SYNC(a_write_only_final, clk, rst_n, mem_req.we |-> ((state_r == amb_pkg::ST_FINAL) || (state_r == amb_pkg::ST_CLEAR)), "RAM write outside final access or clearing")
  `ASSERT_SYNC(a_cross_flagged, clk, rst_n, ((state_r == amb_pkg::ST_WAIT) && (kind_r == amb_pkg::ST_CROSS)) |-> cross_r, "page-cross read without page-cross flag")
  `ASSERT_SYNC(a_idle_pending_last, clk, rst_n, (state_r == amb_pkg::ST_IDLE) |-> (!out_valid_r || out_r.last), "idle while a non-final result is pending")

endmodule

// ----- hw/rtl/cpu6502_address_mode_bus_unit.sv -----
// 6502-style addressing unit: owns the RAM and reports every bus cycle it makes.
//
// in_req carries one request (op, mode, address, data_in, pc_in, x_index,
// y_index); out_res returns one result per bus cycle, or one result if there
// is no bus cycle; the final one has last set and the effective address,
// advanced PC, page-cross flag, mode error and read data. Both channels use
// valid/ready; a transfer happens when both are high at a rising edge.
// A request is taken while the unit is idle; each bus cycle then presents
// its address to the single RAM port and waits for the registered read
// data to come back. A request makes n bus cycles (n = 1 to 5) or none.
// One request is worked on at a time; the next is taken once the last
// result is registered. Reset (rst_n low, synchronous) starts a clearing
// pass that zeroes all MEM_DEPTH bytes of the RAM one byte per cycle, with
// in_req.ready low throughout. When out_res.ready is low the result register
// holds and the sequencer waits before presenting its next RAM access;
// nothing is lost.
module cpu6502_address_mode_bus_unit (
  input  logic      clk,
  input  logic      rst_n,
  amb_in_if.sink    in_req,
  amb_out_if.source out_res
);

  amb_pkg::amb_mem_req_t mem_req;
  logic [7:0]            mem_rdata;

  amb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  amb_ram #(
    .DEPTH (amb_pkg::MEM_DEPTH),
    .DW    (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.idx),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule
